### rtl/ipmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmt_pkg: shared types and constants for the inode policy match table
// Table size, opcode codes and the structs that pass between the control
// logic and the chain of table cells.
// ----------------------------------------------------------------------------
package ipmt_pkg;

    localparam int unsigned TABLE_ENTRIES = 64;
    localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_opcode;

    // Request held stable while the search token walks the chain.
    typedef struct packed {
        t_opcode     opcode;
        logic [63:0] device_id;
        logic [63:0] inode_number;
        logic [31:0] access_mask;
        logic [31:0] block_value;
    } t_req;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             tok;
        logic             hit;
        logic [31:0]      hit_mask;
        logic [31:0]      hit_block;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } t_carry;

    // Commit command broadcast to all cells at the end of a transaction.
    typedef struct packed {
        logic             clear;
        logic             ins;
        logic [IDX_W-1:0] ins_idx;
    } t_cmd;

endpackage

### rtl/inode_policy_match_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inode_policy_match_table: exact-match policy table on (device, inode)
// Fully associative table of TABLE_ENTRIES slots with add, remove, clear
// and lookup, one result transaction per request transaction.
// ----------------------------------------------------------------------------
// Usage: each request transaction ends with a return to idle before the
// next request is taken. Its length from acceptance to the result is set
// by the search token, which walks the row of table cells one cell per
// cycle; every cell compares its stored 128-bit key against the held
// request as the token passes, so the critical path is one key compare and
// a little selection. The result sits in an output register, so a request
// may be accepted while the previous result still waits for i_out_ready.
// Add overwrites a present key in place during the walk; a new key is
// written into the lowest free slot in the cycle the result is loaded. When
// no slot is free the add is refused with o_status = 1. Clear empties the
// table at the end of its transaction. Lookup reports o_matched only when
// the key is present and its mask shares a bit with i_operation_bits;
// o_block_out is zero otherwise. No clearing pass is needed after reset:
// valid bits reset in flip-flops.
// ----------------------------------------------------------------------------
module inode_policy_match_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_device_id,
    input  logic [63:0] i_inode_number,
    input  logic [31:0] i_access_mask,
    input  logic [31:0] i_block_value,
    input  logic [31:0] i_operation_bits,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic        o_matched,
    output logic [31:0] o_block_out
);

    localparam int unsigned N  = ipmt_pkg::TABLE_ENTRIES;
    localparam int unsigned IW = ipmt_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    ipmt_pkg::t_req   r_req;
    logic [31:0]      r_op_bits;
    logic             r_start, n_start;
    ipmt_pkg::t_carry r_res;
    logic             r_out_valid, n_out_valid;
    logic             r_status, n_status;
    logic             r_matched, n_matched;
    logic [31:0]      r_block_out, n_block_out;
    ipmt_pkg::t_cmd   cmd;
    ipmt_pkg::t_carry chain [N+1];
    logic [N:0]       tok_vec;
    logic             in_xact;
    logic             out_free;

    assign in_xact  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Token injected into the first cell, with an empty search state.
    always_comb begin
        chain[0]          = '0;
        chain[0].tok      = r_start;
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        ipmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IW'(g)),
            .i_req   (r_req),
            .i_cmd   (cmd),
            .i_carry (chain[g]),
            .o_carry (chain[g+1])
        );
    end

    for (genvar g = 0; g <= N; g++) begin : g_tok
        assign tok_vec[g] = chain[g].tok;
    end

    // Commit: insert a new key or clear the table as the result is loaded.
    always_comb begin
        cmd       = '0;
        cmd.ins_idx = r_res.free_idx;
        if (r_state == S_DONE && out_free) begin
            cmd.clear = (r_req.opcode == ipmt_pkg::OP_CLEAR);
            cmd.ins   = (r_req.opcode == ipmt_pkg::OP_ADD) && !r_res.hit && r_res.free;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_matched   = r_matched;
        n_block_out = r_block_out;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_start = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (chain[N].tok) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = (r_req.opcode == ipmt_pkg::OP_ADD)
                                  && !r_res.hit && !r_res.free;
                    n_matched   = (r_req.opcode == ipmt_pkg::OP_LOOKUP) && r_res.hit
                                  && ((r_res.hit_mask & r_op_bits) != 32'd0);
                    n_block_out = n_matched ? r_res.hit_block : 32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
        r_status    <= n_status;
        r_matched   <= n_matched;
        r_block_out <= n_block_out;
        if (in_xact) begin
            r_req.opcode       <= ipmt_pkg::t_opcode'(i_opcode);
            r_req.device_id    <= i_device_id;
            r_req.inode_number <= i_inode_number;
            r_req.access_mask  <= i_access_mask;
            r_req.block_value  <= i_block_value;
            r_op_bits          <= i_operation_bits;
        end
        if (r_state == S_WALK && chain[N].tok) begin
            r_res <= chain[N];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_matched   = r_matched;
    assign o_block_out = r_block_out;

    // Only one search token is ever in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one search token in the cell chain");

    // The token leaves the chain only while the control waits for it.
    a_tok_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[N].tok |-> r_state == S_WALK)
        else $error("search token left the chain outside of a walk");

    // A refused add never reports a lookup hit.
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> !o_matched && o_block_out == 32'd0)
        else $error("table-full status together with a match");

    // No insert and clear are issued together.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |-> !cmd.clear)
        else $error("insert and clear issued in the same cycle");

endmodule

### rtl/ipmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmt_cell: one table slot
// Holds one entry, compares it against the request when the search token
// arrives, registers the updated token and hands it to the next cell.
// ----------------------------------------------------------------------------
module ipmt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ipmt_pkg::IDX_W-1:0]  i_idx,
    input  ipmt_pkg::t_req              i_req,
    input  ipmt_pkg::t_cmd              i_cmd,
    input  ipmt_pkg::t_carry            i_carry,
    output ipmt_pkg::t_carry            o_carry
);

    logic             r_valid;
    logic [63:0]      r_dev;
    logic [63:0]      r_ino;
    logic [31:0]      r_mask;
    logic [31:0]      r_block;
    logic             r_tok;
    ipmt_pkg::t_carry r_carry;
    ipmt_pkg::t_carry n_carry;
    logic             hit;
    logic             ins_here;

    assign hit = r_valid && (r_dev == i_req.device_id) && (r_ino == i_req.inode_number);
    assign ins_here = i_cmd.ins && (i_cmd.ins_idx == i_idx);

    always_comb begin
        n_carry = i_carry;
        if (hit) begin
            n_carry.hit       = 1'b1;
            n_carry.hit_mask  = r_mask;
            n_carry.hit_block = r_block;
        end
        if (!i_carry.free && !r_valid) begin
            n_carry.free     = 1'b1;
            n_carry.free_idx = i_idx;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_carry.tok;
            if (i_cmd.clear) begin
                r_valid <= 1'b0;
            end else if (ins_here) begin
                r_valid <= 1'b1;
            end else if (i_carry.tok && hit && i_req.opcode == ipmt_pkg::OP_REMOVE) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Entry payload; keys are unique, so an overwrite acts on the spot.
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (ins_here) begin
            r_dev   <= i_req.device_id;
            r_ino   <= i_req.inode_number;
            r_mask  <= i_req.access_mask;
            r_block <= i_req.block_value;
        end else if (i_carry.tok && hit && i_req.opcode == ipmt_pkg::OP_ADD) begin
            r_mask  <= i_req.access_mask;
            r_block <= i_req.block_value;
        end
    end

    always_comb begin
        o_carry     = r_carry;
        o_carry.tok = r_tok;
    end

endmodule

### dv/ipmt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipmt_tb_pkg: policy table scoreboard
// Keeps a shadow copy of the policy table, predicts the verdict of every
// accepted request and checks the verdicts that the block returns, in order.
// ----------------------------------------------------------------------------
package ipmt_tb_pkg;

    typedef struct {
        bit        status;
        bit        matched;
        bit [31:0] block_out;
    } t_verdict;

    class policy_table_scoreboard;

        bit        shadow_used  [ipmt_pkg::TABLE_ENTRIES];
        bit [63:0] shadow_dev   [ipmt_pkg::TABLE_ENTRIES];
        bit [63:0] shadow_ino   [ipmt_pkg::TABLE_ENTRIES];
        bit [31:0] shadow_mask  [ipmt_pkg::TABLE_ENTRIES];
        bit [31:0] shadow_block [ipmt_pkg::TABLE_ENTRIES];

        t_verdict    pending_verdicts[$];
        int unsigned mismatches;

        function new();
            foreach (shadow_used[i]) shadow_used[i] = 1'b0;
            mismatches = 0;
        endfunction

        function int find_key(bit [63:0] dev, bit [63:0] ino);
            foreach (shadow_used[i])
                if (shadow_used[i] && shadow_dev[i] == dev && shadow_ino[i] == ino)
                    return i;
            return -1;
        endfunction

        function int find_free();
            foreach (shadow_used[i])
                if (!shadow_used[i]) return i;
            return -1;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            foreach (shadow_used[i]) n += shadow_used[i];
            return n;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        // Apply one accepted request to the shadow table and queue its verdict.
        function void note_request(ipmt_pkg::t_opcode op, bit [63:0] dev, bit [63:0] ino,
                                   bit [31:0] mask, bit [31:0] blk, bit [31:0] opbits);
            t_verdict v;
            int       slot;
            v = '{status: 1'b0, matched: 1'b0, block_out: 32'd0};
            case (op)
                ipmt_pkg::OP_ADD: begin
                    slot = find_key(dev, ino);
                    if (slot < 0) begin
                        slot = find_free();
                        if (slot >= 0) begin
                            shadow_used[slot] = 1'b1;
                            shadow_dev[slot]  = dev;
                            shadow_ino[slot]  = ino;
                        end
                    end
                    if (slot >= 0) begin
                        shadow_mask[slot]  = mask;
                        shadow_block[slot] = blk;
                    end else begin
                        v.status = 1'b1;
                    end
                end
                ipmt_pkg::OP_REMOVE: begin
                    slot = find_key(dev, ino);
                    if (slot >= 0) shadow_used[slot] = 1'b0;
                end
                ipmt_pkg::OP_CLEAR: begin
                    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
                end
                default: begin
                    slot = find_key(dev, ino);
                    if (slot >= 0 && (shadow_mask[slot] & opbits) != 32'd0) begin
                        v.matched   = 1'b1;
                        v.block_out = shadow_block[slot];
                    end
                end
            endcase
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(bit status, bit matched, bit [31:0] block_out);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result transaction: status=%0d matched=%0d block_out=%h",
                       status, matched, block_out);
                mismatches++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (status != v.status) begin
                $error("status: expected %0d, actual %0d", v.status, status);
                mismatches++;
            end
            if (matched != v.matched) begin
                $error("matched: expected %0d, actual %0d", v.matched, matched);
                mismatches++;
            end
            if (block_out != v.block_out) begin
                $error("block_out: expected %h, actual %h", v.block_out, block_out);
                mismatches++;
            end
        endfunction

    endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for inode_policy_match_table
// Directed requests cover the key and data extremes and each opcode corner,
// then random traffic mixes add/remove/clear/lookup over a small key pool
// with periodic fill bursts that drive the table to full. Both channels
// idle at random; a scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS = 800;
    localparam int POOL_KEYS    = 16;
    localparam int CYCLE_LIMIT  = 500000;   // hang guard: the items' transaction time plus stalls, with margin
    localparam int DRAIN_CYCLES = 80;       // settle time after the last result

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_opcode;
    logic [63:0] i_device_id;
    logic [63:0] i_inode_number;
    logic [31:0] i_access_mask;
    logic [31:0] i_block_value;
    logic [31:0] i_operation_bits;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_status;
    logic        o_matched;
    logic [31:0] o_block_out;

    ipmt_tb_pkg::policy_table_scoreboard sb;

    // When set, neither side idles: back-to-back transactions for a while.
    bit          no_idle;
    int unsigned cycle_count;

    // Key pool for the mixed traffic; odd entries are near misses of even ones.
    logic [63:0] pool_dev [POOL_KEYS];
    logic [63:0] pool_ino [POOL_KEYS];

    inode_policy_match_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_device_id      (i_device_id),
        .i_inode_number   (i_inode_number),
        .i_access_mask    (i_access_mask),
        .i_block_value    (i_block_value),
        .i_operation_bits (i_operation_bits),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_matched        (o_matched),
        .o_block_out      (o_block_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 38);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mask / operation bits biased toward zero, all ones and single bits so
    // that both hits and "no shared bit" misses are common.
    function automatic logic [31:0] pick_bits();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic void refill_pool();
        for (int k = 0; k < POOL_KEYS; k += 2) begin
            case ($urandom_range(0, 5))
                0: begin
                    pool_dev[k] = 64'd0;
                    pool_ino[k] = rand64();
                end
                1: begin
                    pool_dev[k] = 64'hFFFF_FFFF_FFFF_FFFF;
                    pool_ino[k] = 64'hFFFF_FFFF_FFFF_FFFF;
                end
                default: begin
                    pool_dev[k] = rand64();
                    pool_ino[k] = rand64();
                end
            endcase
            // near miss: one bit flipped in either half of the key
            if ($urandom_range(0, 1)) begin
                pool_dev[k+1] = pool_dev[k];
                pool_ino[k+1] = pool_ino[k] ^ (64'd1 << $urandom_range(0, 63));
            end else begin
                pool_dev[k+1] = pool_dev[k] ^ (64'd1 << $urandom_range(0, 63));
                pool_ino[k+1] = pool_ino[k];
            end
        end
    endfunction

    // Drive one request transaction and hand it to the scoreboard once accepted.
    // Valid is only lowered for an idle gap chosen before the next request.
    task automatic send_request(input ipmt_pkg::t_opcode op, input logic [63:0] dev,
                                input logic [63:0] ino, input logic [31:0] mask,
                                input logic [31:0] blk, input logic [31:0] opbits);
        while (idle_now()) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_device_id      <= dev;
        i_inode_number   <= ino;
        i_access_mask    <= mask;
        i_block_value    <= blk;
        i_operation_bits <= opbits;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, dev, ino, mask, blk, opbits);
    endtask

    // Fill the table with fresh keys until full, then probe the full table:
    // refused adds, an in-place overwrite, a remove, a refill and lookups.
    task automatic fill_burst(inout int sent);
        logic [63:0] fill_dev[$];
        logic [63:0] fill_ino[$];
        logic [63:0] d;
        logic [63:0] n;
        int          pick;
        // an already full table is cleared so that the probes have fill keys
        if ($urandom_range(0, 1) || sb.occupancy() == ipmt_pkg::TABLE_ENTRIES) begin
            send_request(ipmt_pkg::OP_CLEAR, rand64(), rand64(), $urandom, $urandom,
                         $urandom);
            sent++;
        end
        while (sb.occupancy() < ipmt_pkg::TABLE_ENTRIES) begin
            d = rand64();
            n = rand64();
            fill_dev.push_back(d);
            fill_ino.push_back(n);
            send_request(ipmt_pkg::OP_ADD, d, n, pick_bits(), $urandom, $urandom);
            sent++;
        end
        for (int k = 0; k < 14; k++) begin
            pick = $urandom_range(0, fill_dev.size() - 1);
            case (k % 7)
                0, 1:    send_request(ipmt_pkg::OP_ADD, rand64(), rand64(),
                                      $urandom, $urandom, $urandom);
                2:       send_request(ipmt_pkg::OP_ADD, fill_dev[pick], fill_ino[pick],
                                      pick_bits(), $urandom, $urandom);
                3:       send_request(ipmt_pkg::OP_REMOVE, fill_dev[pick], fill_ino[pick],
                                      $urandom, $urandom, $urandom);
                4:       send_request(ipmt_pkg::OP_ADD, rand64(), rand64(),
                                      pick_bits(), $urandom, $urandom);
                default: send_request(ipmt_pkg::OP_LOOKUP, fill_dev[pick], fill_ino[pick],
                                      $urandom, $urandom, pick_bits());
            endcase
            sent++;
        end
    endtask

    // One mixed request over the key pool, with some noise keys.
    task automatic mixed_request();
        logic [63:0] d;
        logic [63:0] n;
        int          r;
        int          k;
        k = $urandom_range(0, POOL_KEYS - 1);
        d = pool_dev[k];
        n = pool_ino[k];
        if ($urandom_range(0, 99) < 8) begin
            d = rand64();
            n = rand64();
        end
        r = $urandom_range(0, 99);
        if (r < 35)
            send_request(ipmt_pkg::OP_ADD, d, n, pick_bits(), $urandom, $urandom);
        else if (r < 53)
            send_request(ipmt_pkg::OP_REMOVE, d, n, $urandom, $urandom, $urandom);
        else if (r < 55)
            send_request(ipmt_pkg::OP_CLEAR, d, n, $urandom, $urandom, $urandom);
        else
            send_request(ipmt_pkg::OP_LOOKUP, d, n, $urandom, $urandom, pick_bits());
    endtask

    // Result side: ready changes at the falling edge, results sampled at the rising.
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            i_out_ready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_matched, o_block_out);
    end

    initial begin
        logic [63:0] ones64;
        int          sent;
        ones64           = 64'hFFFF_FFFF_FFFF_FFFF;
        sb               = new();
        no_idle          = 1'b0;
        sent             = 0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_opcode         = ipmt_pkg::OP_ADD;
        i_device_id      = '0;
        i_inode_number   = '0;
        i_access_mask    = '0;
        i_block_value    = '0;
        i_operation_bits = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // empty table: lookup misses, remove of absent key is a no-op
        send_request(ipmt_pkg::OP_LOOKUP, 64'd0, 64'd0, $urandom, $urandom, 32'hFFFF_FFFF);
        send_request(ipmt_pkg::OP_REMOVE, ones64, ones64, $urandom, $urandom, $urandom);
        // extreme keys and data, deny and audit entries
        send_request(ipmt_pkg::OP_ADD, ones64, ones64, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     $urandom);
        send_request(ipmt_pkg::OP_ADD, 64'd0, 64'd0, 32'h0000_0001, 32'd0, $urandom);
        send_request(ipmt_pkg::OP_LOOKUP, ones64, ones64, $urandom, $urandom,
                     32'h8000_0000);
        send_request(ipmt_pkg::OP_LOOKUP, 64'd0, 64'd0, $urandom, $urandom, 32'h0000_0001);
        // key present but no shared bit, and an empty operation
        send_request(ipmt_pkg::OP_LOOKUP, 64'd0, 64'd0, $urandom, $urandom, 32'hFFFF_FFFE);
        send_request(ipmt_pkg::OP_LOOKUP, ones64, ones64, $urandom, $urandom, 32'd0);
        // overwrite in place
        send_request(ipmt_pkg::OP_ADD, ones64, ones64, 32'h0000_0100, 32'h5A5A_A5A5,
                     $urandom);
        send_request(ipmt_pkg::OP_LOOKUP, ones64, ones64, $urandom, $urandom,
                     32'h0000_0100);
        send_request(ipmt_pkg::OP_LOOKUP, ones64, ones64, $urandom, $urandom,
                     32'hFFFF_FEFF);
        // near-miss keys: one bit off in either half
        send_request(ipmt_pkg::OP_LOOKUP, ones64, ones64 ^ 64'd1, $urandom, $urandom,
                     32'hFFFF_FFFF);
        send_request(ipmt_pkg::OP_LOOKUP, ones64 ^ 64'h8000_0000_0000_0000, ones64,
                     $urandom, $urandom, 32'hFFFF_FFFF);
        // remove one key, the other stays
        send_request(ipmt_pkg::OP_REMOVE, ones64, ones64, $urandom, $urandom, $urandom);
        send_request(ipmt_pkg::OP_LOOKUP, ones64, ones64, $urandom, $urandom,
                     32'hFFFF_FFFF);
        send_request(ipmt_pkg::OP_LOOKUP, 64'd0, 64'd0, $urandom, $urandom, 32'hFFFF_FFFF);
        // clear empties everything
        send_request(ipmt_pkg::OP_CLEAR, rand64(), rand64(), $urandom, $urandom, $urandom);
        send_request(ipmt_pkg::OP_LOOKUP, 64'd0, 64'd0, $urandom, $urandom, 32'hFFFF_FFFF);
        send_request(ipmt_pkg::OP_REMOVE, 64'd0, 64'd0, $urandom, $urandom, $urandom);
        // re-add after clear, top mask bit only
        send_request(ipmt_pkg::OP_ADD, 64'd0, 64'd0, 32'h8000_0000, 32'h0000_0001,
                     $urandom);
        send_request(ipmt_pkg::OP_LOOKUP, 64'd0, 64'd0, $urandom, $urandom, 32'h8000_0001);
        send_request(ipmt_pkg::OP_CLEAR, rand64(), rand64(), $urandom, $urandom, $urandom);

        // ---- random ----
        refill_pool();
        while (sent < RANDOM_ITEMS) begin
            // a stretch of back-to-back traffic on both sides
            no_idle = (sent >= 200 && sent < 350);
            if (sent == 100 || sent == 420 || sent == 650) begin
                fill_burst(sent);
                refill_pool();
            end else begin
                if ($urandom_range(0, 99) == 0) refill_pool();
                mixed_request();
                sent++;
            end
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // wait for every expected result, then let the block settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
